// ===== rtl/core/nsr_pkg.sv =====
// Shared constants and types for the Newton square root block.
// No dependencies; imported by nsr_divider, newton_square_root and the testbench.
package nsr_pkg;

    // Field widths
    localparam int VALUE_W  = 10;
    localparam int APPROX_W = 32;
    localparam int DIFF_W   = 34;
    localparam int TOL_W    = 23;
    localparam int STATUS_W = 2;

    // Algorithm constants
    localparam int FRAC_BITS   = 22;
    localparam int MAX_STEPS   = 32;
    localparam int VALUE_LIMIT = 1000;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(419);

    // Step counter holds 0 .. MAX_STEPS
    localparam int STEP_W = $clog2(MAX_STEPS + 1);

    // Divider: numerator is value << 2*FRAC_BITS; its part above the
    // quotient width seeds the remainder, the rest is all zero bits.
    localparam int REM_INIT_W = VALUE_W + 2 * FRAC_BITS - APPROX_W;
    localparam int DIV_CNT_W  = $clog2(APPROX_W);

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_LIMIT = 2'd2;

    // Divider handshake toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== rtl/core/newton_square_root.sv =====
// Newton square root: one value in, one result beat per iteration out.
// Each step: the divider forms 32 quotient bits and flags done, then the sequencer waits
// for a free output register, emits the step and restarts; a run has up to 32 steps.
// An out-of-range value gives one error beat in the cycle after acceptance.
// Reset (rst_n, async, low) idles the sequencer and sets tolerance to 419.
// Depends on nsr_pkg and nsr_divider.
module newton_square_root (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wen,
    input  logic [nsr_pkg::TOL_W-1:0]    cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [nsr_pkg::VALUE_W-1:0]  value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [nsr_pkg::APPROX_W-1:0] approximation,
    output logic signed [nsr_pkg::DIFF_W-1:0] difference,
    output logic [nsr_pkg::STATUS_W-1:0] status,
    output logic                         last
);
    import nsr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_UPDATE
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [TOL_W-1:0]      tol_reg;
    logic [VALUE_W-1:0]    operand_reg;
    logic [VALUE_W-1:0]    operand_next;
    logic [APPROX_W-1:0]   guess_reg;
    logic [APPROX_W-1:0]   guess_next;
    logic [STEP_W-1:0]     step_cnt_reg;
    logic [STEP_W-1:0]     step_cnt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [APPROX_W-1:0]   approx_reg;
    logic [APPROX_W-1:0]   approx_next;
    logic [DIFF_W-1:0]     diff_reg;
    logic [DIFF_W-1:0]     diff_next;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    logic                  last_reg;
    logic                  last_next;

    logic                  out_free;
    logic                  in_accept;
    logic                  in_range;
    logic                  div_start;
    logic [APPROX_W-1:0]   div_divisor;
    logic [REM_INIT_W-1:0] div_rem_init;
    logic [APPROX_W-1:0]   quot;
    div_status_t           div_stat;
    logic [APPROX_W:0]     sum;
    logic [APPROX_W-1:0]   new_x;
    logic [APPROX_W-1:0]   mag;
    logic                  converged;
    logic                  at_limit;

    // Output register is free when empty or draining this cycle
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == ST_IDLE) && out_free);
    assign in_accept = in_valid && !in_stall;
    assign in_range  = (value != '0) && ({1'b0, value} < (VALUE_W + 1)'(VALUE_LIMIT));

    // Newton update: halve both terms, add back the carry of two odd halves
    assign sum   = {2'b00, guess_reg[APPROX_W-1:1]} + {2'b00, quot[APPROX_W-1:1]}
                 + (APPROX_W + 1)'(guess_reg[0] & quot[0]);
    assign new_x = sum[APPROX_W-1:0];
    assign mag   = (guess_reg >= new_x) ? (guess_reg - new_x) : (new_x - guess_reg);
    assign converged = (mag <= {{(APPROX_W - TOL_W){1'b0}}, tol_reg});
    assign at_limit  = (step_cnt_reg == STEP_W'(MAX_STEPS - 1));

    // Divider operands: fresh value on accept, new guess on later steps
    assign div_rem_init = (state_reg == ST_IDLE)
                        ? {value, {(REM_INIT_W - VALUE_W){1'b0}}}
                        : {operand_reg, {(REM_INIT_W - VALUE_W){1'b0}}};
    assign div_divisor  = (state_reg == ST_IDLE)
                        ? {value, {FRAC_BITS{1'b0}}}
                        : new_x;

    always_comb
    begin
        state_next     = state_reg;
        operand_next   = operand_reg;
        guess_next     = guess_reg;
        step_cnt_next  = step_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        approx_next    = approx_reg;
        diff_next      = diff_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        div_start      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_range)
                    begin
                        operand_next  = value;
                        guess_next    = {value, {FRAC_BITS{1'b0}}};
                        step_cnt_next = '0;
                        div_start     = 1'b1;
                        state_next    = ST_DIVIDE;
                    end
                    else
                    begin
                        // Single error beat, state untouched
                        out_valid_next = 1'b1;
                        approx_next    = '0;
                        diff_next      = '0;
                        status_next    = STAT_RANGE;
                        last_next      = 1'b1;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                // Wait for the output register, then emit this step
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    approx_next    = new_x;
                    diff_next      = {2'b00, guess_reg} - {2'b00, new_x};
                    status_next    = (!converged && at_limit) ? STAT_LIMIT : STAT_OK;
                    last_next      = converged || at_limit;
                    guess_next     = new_x;
                    step_cnt_next  = step_cnt_reg + 1'b1;
                    if (converged || at_limit)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, configuration and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tol_reg       <= TOL_RESET;
            operand_reg   <= '0;
            guess_reg     <= '0;
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            operand_reg   <= operand_next;
            guess_reg     <= guess_next;
            step_cnt_reg  <= step_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
            begin
                tol_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        approx_reg <= approx_next;
        diff_reg   <= diff_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    nsr_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem_init),
        .divisor  (div_divisor),
        .quotient (quot),
        .status   (div_stat)
    );

    assign out_valid     = out_valid_reg;
    assign approximation = approx_reg;
    assign difference    = diff_reg;
    assign status        = status_reg;
    assign last          = last_reg;

`ifndef SYNTHESIS
    // Divider finishes only while the sequencer waits for it
    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIVIDE))
        else $error("divider done outside divide state");

    // Divider is never restarted while running
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    // Step counter never passes the step limit
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_cnt_reg <= STEP_W'(MAX_STEPS))
        else $error("step counter beyond limit");

    // A step-limit beat closes the run at the full step count
    a_limit_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STAT_LIMIT) |->
            (last && step_cnt_reg == STEP_W'(MAX_STEPS)))
        else $error("step limit beat inconsistent");
`endif

endmodule

// ===== rtl/core/nsr_divider.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on nsr_pkg; instantiated by newton_square_root.
module nsr_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [nsr_pkg::REM_INIT_W-1:0] rem_init,
    input  logic [nsr_pkg::APPROX_W-1:0]   divisor,
    output logic [nsr_pkg::APPROX_W-1:0]   quotient,
    output nsr_pkg::div_status_t           status
);
    import nsr_pkg::*;

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIV_CNT_W-1:0]  cnt_next;
    logic [APPROX_W-1:0]   rem_reg;
    logic [APPROX_W-1:0]   rem_next;
    logic [APPROX_W-1:0]   dvs_reg;
    logic [APPROX_W-1:0]   dvs_next;
    logic [APPROX_W-1:0]   quo_reg;
    logic [APPROX_W-1:0]   quo_next;
    logic [APPROX_W:0]     trial;
    logic                  fits;

    // Shift in one zero numerator bit and try the subtraction
    assign trial = {rem_reg, 1'b0};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = {{(APPROX_W - REM_INIT_W){1'b0}}, rem_init};
            dvs_next  = divisor;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? APPROX_W'(trial - {1'b0, dvs_reg}) : trial[APPROX_W-1:0];
            quo_next = {quo_reg[APPROX_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(APPROX_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== tb/newton_square_root_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for newton_square_root: a directed table, then random values.
// Every result beat is checked against its table entry or an in-bench Newton iteration predictor; needs nsr_pkg.
module newton_square_root_test;
    import nsr_pkg::*;

    localparam int CYCLE_LIMIT  = 5_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_VALUES  = 50;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [APPROX_W-1:0]       approximation;
        logic signed [DIFF_W-1:0]  difference;
        logic [STATUS_W-1:0]       status;
        logic                      last;
    } root_beat_t;

    typedef enum logic {ROW_VALUE, ROW_TOLERANCE} row_kind_t;

    typedef struct packed {
        row_kind_t     kind;
        logic [TOL_W-1:0] arg;
        logic          typed;
        root_beat_t    beat;
    } stim_row_t;

    // Beats that can be read off directly: range error, and the root of one
    localparam root_beat_t RANGE_BEAT = '{'0, '0, STAT_RANGE, 1'b1};
    localparam root_beat_t UNIT_BEAT  = '{32'h0040_0000, '0, STAT_OK, 1'b1};
    localparam root_beat_t NO_BEAT    = '0;
    localparam int DIRECTED_ROWS = 26;

    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_VALUE,     23'd1,       1'b1, UNIT_BEAT},
        '{ROW_VALUE,     23'd0,       1'b1, RANGE_BEAT},
        '{ROW_VALUE,     23'd1000,    1'b1, RANGE_BEAT},
        '{ROW_VALUE,     23'd1023,    1'b1, RANGE_BEAT},
        '{ROW_VALUE,     23'd999,     1'b0, NO_BEAT},
        '{ROW_VALUE,     23'd2,       1'b0, NO_BEAT},
        '{ROW_VALUE,     23'd4,       1'b0, NO_BEAT},
        '{ROW_VALUE,     23'd512,     1'b0, NO_BEAT},
        '{ROW_VALUE,     23'd511,     1'b0, NO_BEAT},
        '{ROW_VALUE,     23'd341,     1'b0, NO_BEAT},
        '{ROW_VALUE,     23'd682,     1'b0, NO_BEAT},
        '{ROW_TOLERANCE, 23'd0,       1'b0, NO_BEAT},
        '{ROW_VALUE,     23'd999,     1'b0, NO_BEAT},
        '{ROW_VALUE,     23'd2,       1'b0, NO_BEAT},
        '{ROW_VALUE,     23'd1,       1'b1, UNIT_BEAT},
        '{ROW_VALUE,     23'd998,     1'b0, NO_BEAT},
        '{ROW_TOLERANCE, 23'h7FFFFF,  1'b0, NO_BEAT},
        '{ROW_VALUE,     23'd999,     1'b0, NO_BEAT},
        '{ROW_VALUE,     23'd3,       1'b0, NO_BEAT},
        '{ROW_VALUE,     23'd1000,    1'b1, RANGE_BEAT},
        '{ROW_TOLERANCE, 23'd4194304, 1'b0, NO_BEAT},
        '{ROW_VALUE,     23'd100,     1'b0, NO_BEAT},
        '{ROW_VALUE,     23'd999,     1'b0, NO_BEAT},
        '{ROW_TOLERANCE, 23'd1,       1'b0, NO_BEAT},
        '{ROW_VALUE,     23'd500,     1'b0, NO_BEAT},
        '{ROW_VALUE,     23'd7,       1'b0, NO_BEAT}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wen = 1'b0;
    logic [TOL_W-1:0]     cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [VALUE_W-1:0]   value = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [APPROX_W-1:0]  approximation;
    logic signed [DIFF_W-1:0] difference;
    logic [STATUS_W-1:0]  status;
    logic                 last;

    root_beat_t           expected_beats [$];
    logic [TOL_W-1:0]     tolerance_setting = TOL_RESET;
    int                   failure_count = 0;
    int                   cycle_count = 0;

    newton_square_root DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .approximation (approximation),
        .difference    (difference),
        .status        (status),
        .last          (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Queue the beats of one Newton run, or the single range error beat
    function automatic void predict_root_run(input logic [VALUE_W-1:0] v);
        logic [63:0] x_old;
        logic [63:0] quotient;
        logic [63:0] x_new;
        logic [63:0] step_size;
        int          steps;
        bit          done;
        root_beat_t  beat;
        if (v == 0 || v >= VALUE_LIMIT)
        begin
            expected_beats.push_back(RANGE_BEAT);
            return;
        end
        x_old = 64'(v) << FRAC_BITS;
        steps = 0;
        done = 1'b0;
        while (!done)
        begin
            // v / x in Q10.22 is (v << 2F) / x; fits easily in 64 bits here
            quotient = (64'(v) << (2 * FRAC_BITS)) / x_old;
            x_new = (x_old >> 1) + (quotient >> 1) + (x_old & quotient & 64'd1);
            step_size = (x_old >= x_new) ? x_old - x_new : x_new - x_old;
            done = (step_size <= 64'(tolerance_setting));
            steps++;
            beat.status = STAT_OK;
            if (!done && steps >= MAX_STEPS)
            begin
                done = 1'b1;
                beat.status = STAT_LIMIT;
            end
            beat.approximation = x_new[APPROX_W-1:0];
            beat.difference = DIFF_W'(x_old - x_new);
            beat.last = done;
            expected_beats.push_back(beat);
            x_old = x_new;
        end
    endfunction

    // Present one value beat and hold it until accepted; valid stays high
    task automatic send_value(input logic [VALUE_W-1:0] v, input logic typed,
                              input root_beat_t typed_beat);
        in_valid <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (in_stall);
        if (typed)
            expected_beats.push_back(typed_beat);
        else
            predict_root_run(v);
    endtask

    // Drop valid, let the block go idle, then write the tolerance register
    task automatic write_tolerance(input logic [TOL_W-1:0] tol);
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_wdata <= tol;
        tolerance_setting = tol;
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    function automatic logic [TOL_W-1:0] pick_tolerance();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return TOL_RESET;
            2: return TOL_W'($urandom_range(0, 4096));
            3: return TOL_W'($urandom_range(0, 23'h7FFFFF));
            default: return '1;
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 9) == 0)
            return VALUE_W'($urandom_range(0, 1023));
        return VALUE_W'($urandom_range(1, VALUE_LIMIT - 1));
    endfunction

    // Stimulus: reset, directed table, then random phases
    initial
    begin : stimulus
        int burst_left;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table back to back
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (DIRECTED[i].kind == ROW_TOLERANCE)
                write_tolerance(DIRECTED[i].arg);
            else
                send_value(DIRECTED[i].arg[VALUE_W-1:0], DIRECTED[i].typed,
                           DIRECTED[i].beat);
        end

        // Random phases, each under its own tolerance, sender in bursts
        burst_left = 0;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_tolerance(pick_tolerance());
            for (int n = 0; n < PHASE_VALUES; n++)
            begin
                send_value(pick_value(), 1'b0, NO_BEAT);
                if (n == PHASE_VALUES - 1)
                    ;
                else if (burst_left > 0)
                    burst_left--;
                else
                begin
                    in_valid <= 1'b0;
                    if ($urandom_range(0, 1) == 0)
                        repeat ($urandom_range(1, 10)) @(posedge clk);
                    else
                        repeat ($urandom_range(1, 700)) @(posedge clk);
                    burst_left = $urandom_range(0, 6);
                end
            end
        end

        // Drain and finish
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failure_count == 0 && expected_beats.size() == 0)
            $display("newton_square_root regression: pass");
        else
            $display("newton_square_root regression: fail");
        $finish;
    end

    // Receiver stall: switch between free, light, even and heavy stretches
    int stall_mode = 0;
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(5, 80);
        end
        else
            stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 7) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Check each accepted result beat against the oldest expectation
    always @(posedge clk)
    begin : check_beats
        root_beat_t got;
        root_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.approximation = approximation;
            got.difference = difference;
            got.status = status;
            got.last = last;
            if (expected_beats.size() == 0)
            begin
                failure_count++;
                if (failure_count <= REPORT_LIMIT)
                    $display("unexpected beat: approx %h diff %h status %0d last %0b",
                             got.approximation, got.difference, got.status, got.last);
            end
            else
            begin
                want = expected_beats.pop_front();
                if (got !== want)
                begin
                    failure_count++;
                    if (failure_count <= REPORT_LIMIT)
                        $display({"mismatch: expected approx %h diff %h status %0d last %0b,",
                                  " got approx %h diff %h status %0d last %0b"},
                                 want.approximation, want.difference, want.status,
                                 want.last, got.approximation, got.difference,
                                 got.status, got.last);
                end
            end
        end
    end

    // Hang guard
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("newton_square_root regression: fail");
        $finish;
    end

endmodule

// ===== newton_square_root.f =====
rtl/core/nsr_pkg.sv
rtl/core/nsr_divider.sv
rtl/core/newton_square_root.sv
tb/newton_square_root_test.sv
